@@ design/sstf_pkg.sv @@
`timescale 1ns / 1ps

package sstf_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);

   localparam int CYL_W = 16;
   localparam int SUM_W = 22;
   localparam int IDX_W = 6;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef logic [CYL_W-1:0] cyl_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      cyl_type           data;
   } store_wr_type;

endpackage

@@ design/sstf_store.sv @@
`timescale 1ns / 1ps

module sstf_store (
   input  logic                  clock,
   input  sstf_pkg::store_wr_type wr,
   input  logic [sstf_pkg::ADDR_W-1:0] rd_addr,
   output sstf_pkg::cyl_type      rd_data
);
   import sstf_pkg::*;

   cyl_type mem [MAX_REQUESTS];
   cyl_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sstf_disk_scheduler.sv @@
`timescale 1ns / 1ps

// channel | ports                                        | direction
// req     | req_valid req_ready req_cmd req_position     | in
// rsp     | rsp_valid rsp_ready rsp_serviced_cylinder    | out
//         |   rsp_move_distance rsp_total_movement       |
//         |   rsp_service_index rsp_last rsp_empty_res   |
//
// a load or a run with no requests is handled without leaving the idle state.
// service step i of a run with n requests scans slots i..n-1 through the
// single read port of the request store, then writes back its swap in the
// done state once the result register is free.
// reset is synchronous and clears all control state; store contents stay.
// a stalled result holds the scan before its write-back; the input takes no
// transfer while a result is still waiting.

module sstf_disk_scheduler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic [15:0]              req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              rsp_serviced_cylinder,
   output logic [15:0]              rsp_move_distance,
   output logic [21:0]              rsp_total_movement,
   output logic [5:0]               rsp_service_index,
   output logic                     rsp_last,
   output logic                     rsp_empty_res
);
   import sstf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   cyl_type           head_ff, head_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [ADDR_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              rd_v_ff, rd_v_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   cyl_type           best_val_ff, best_val_in;
   cyl_type           best_dist_ff, best_dist_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   cyl_type           first_val_ff, first_val_in;

   logic              out_v_ff, out_v_in;
   cyl_type           out_cyl_ff, out_cyl_in;
   cyl_type           out_dist_ff, out_dist_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic              out_last_ff, out_last_in;
   logic              out_empty_ff, out_empty_in;

   store_wr_type      wr;
   logic [ADDR_W-1:0] rd_addr;
   cyl_type           rd_data;
   cyl_type           rd_dist;
   logic [CNT_W-1:0]  last_idx;
   logic              out_free;
   logic              req_xfer;
   logic              step_last;
   logic [SUM_W-1:0]  sum_next;

   sstf_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !out_v_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign last_idx  = count_ff - CNT_W'(1);
   assign rd_addr   = scan_ff[ADDR_W-1:0];
   assign rd_dist   = (rd_data >= head_ff) ? (rd_data - head_ff) : (head_ff - rd_data);
   assign step_last = (step_ff == last_idx[ADDR_W-1:0]);
   assign sum_next  = sum_ff + SUM_W'(best_dist_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      rd_v_in      = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_val_in  = best_val_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      first_val_in = first_val_ff;
      out_v_in     = out_v_ff && !rsp_ready;
      out_cyl_in   = out_cyl_ff;
      out_dist_in  = out_dist_ff;
      out_sum_in   = out_sum_ff;
      out_idx_in   = out_idx_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      wr.en        = 1'b0;
      wr.addr      = count_ff[ADDR_W-1:0];
      wr.data      = req_position;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == CMD_LOAD) begin
                  if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                     wr.en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  head_in = req_position;
                  sum_in  = '0;
                  step_in = '0;
                  scan_in = '0;
                  if (count_ff == '0) begin
                     out_v_in     = 1'b1;
                     out_cyl_in   = '0;
                     out_dist_in  = '0;
                     out_sum_in   = '0;
                     out_idx_in   = '0;
                     out_last_in  = 1'b0;
                     out_empty_in = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the data in the cycle after
            if (scan_ff < count_ff) begin
               rd_v_in   = 1'b1;
               rd_idx_in = scan_ff[ADDR_W-1:0];
               scan_in   = scan_ff + CNT_W'(1);
            end
            if (rd_v_ff) begin
               if (rd_idx_ff == step_ff) begin
                  first_val_in = rd_data;
                  best_val_in  = rd_data;
                  best_dist_in = rd_dist;
                  best_idx_in  = rd_idx_ff;
               end else if (best_dist_ff >= rd_dist) begin
                  // ties go to the later slot
                  best_val_in  = rd_data;
                  best_dist_in = rd_dist;
                  best_idx_in  = rd_idx_ff;
               end
               if (rd_idx_ff == last_idx[ADDR_W-1:0]) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_v_in     = 1'b1;
               out_cyl_in   = best_val_ff;
               out_dist_in  = best_dist_ff;
               out_sum_in   = sum_next;
               out_idx_in   = IDX_W'(step_ff);
               out_last_in  = step_last;
               out_empty_in = 1'b0;
               head_in      = best_val_ff;
               sum_in       = sum_next;
               // swap: the chosen slot takes the old value of the service slot
               wr.en        = 1'b1;
               wr.addr      = best_idx_ff;
               wr.data      = first_val_ff;
               if (step_last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in  = step_ff + ADDR_W'(1);
                  scan_in  = CNT_W'(step_ff) + CNT_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         sum_ff   <= '0;
         step_ff  <= '0;
         scan_ff  <= '0;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         sum_ff   <= sum_in;
         step_ff  <= step_in;
         scan_ff  <= scan_in;
         rd_v_ff  <= rd_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      best_val_ff  <= best_val_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      first_val_ff <= first_val_in;
      out_cyl_ff   <= out_cyl_in;
      out_dist_ff  <= out_dist_in;
      out_sum_ff   <= out_sum_in;
      out_idx_ff   <= out_idx_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_serviced_cylinder = out_cyl_ff;
   assign rsp_move_distance     = out_dist_ff;
   assign rsp_total_movement    = out_sum_ff;
   assign rsp_service_index     = out_idx_ff;
   assign rsp_last              = out_last_ff;
   assign rsp_empty_res         = out_empty_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import sstf_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 460;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLDOFF_CYCLES = 400;

   typedef struct {
      logic    cmd;
      cyl_type position;
   } disk_cmd_type;

   typedef struct {
      logic [15:0] cylinder;
      logic [15:0] distance;
      logic [21:0] total;
      logic [5:0]  index;
      logic        last;
      logic        empty;
   } service_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_LOAD;
   logic [15:0] req_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_serviced_cylinder;
   logic [15:0] rsp_move_distance;
   logic [21:0] rsp_total_movement;
   logic [5:0]  rsp_service_index;
   logic        rsp_last;
   logic        rsp_empty_res;

   disk_cmd_type pending_cmds[$];
   service_type  service_q[$];

   // shadow of the scheduler state
   cyl_type     shadow_store[64];
   int          shadow_count = 0;
   cyl_type     shadow_head = '0;

   bit failed = 1'b0;
   int cycle_count = 0;
   int results_seen = 0;
   int gap_left = 0;
   int burst_left = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;
   int stall_mode = 0;
   int stall_phase = 0;

   sstf_disk_scheduler dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_position          (req_position),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_serviced_cylinder (rsp_serviced_cylinder),
      .rsp_move_distance     (rsp_move_distance),
      .rsp_total_movement    (rsp_total_movement),
      .rsp_service_index     (rsp_service_index),
      .rsp_last              (rsp_last),
      .rsp_empty_res         (rsp_empty_res)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] seek_distance(cyl_type a, cyl_type b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // apply one accepted transfer to the shadow state, queueing the services it causes
   task automatic schedule_transfer(logic cmd, cyl_type pos);
      service_type svc;
      int          best;
      cyl_type     swap;
      logic [15:0] d;
      logic [21:0] sum;
      if (cmd == CMD_LOAD) begin
         if (shadow_count < MAX_REQUESTS) begin
            shadow_store[shadow_count] = pos;
            shadow_count++;
         end
      end else begin
         shadow_head = pos;
         sum = '0;
         if (shadow_count == 0) begin
            svc = '{cylinder: '0, distance: '0, total: '0, index: '0, last: 1'b0,
                    empty: 1'b1};
            service_q.push_back(svc);
         end else begin
            for (int i = 0; i < shadow_count; i++) begin
               best = i;
               for (int j = i + 1; j < shadow_count; j++) begin
                  // equal distance goes to the later slot
                  if (seek_distance(shadow_store[best], shadow_head) >=
                      seek_distance(shadow_store[j], shadow_head))
                     best = j;
               end
               d = seek_distance(shadow_store[best], shadow_head);
               sum = sum + d;
               shadow_head = shadow_store[best];
               swap = shadow_store[best];
               shadow_store[best] = shadow_store[i];
               shadow_store[i] = swap;
               svc.cylinder = shadow_head;
               svc.distance = d;
               svc.total = sum;
               svc.index = i[5:0];
               svc.last = (i + 1 == shadow_count);
               svc.empty = 1'b0;
               service_q.push_back(svc);
            end
            shadow_count = 0;
         end
      end
   endtask

   task automatic add_cmd(logic cmd, cyl_type pos);
      disk_cmd_type c;
      c.cmd = cmd;
      c.position = pos;
      pending_cmds.push_back(c);
   endtask

   // content styles: spread out, clustered near a center, or extremes and repeats
   function automatic cyl_type pick_cylinder(int style, cyl_type center);
      int r;
      if (style == 0)
         return cyl_type'($urandom_range(0, 65535));
      if (style == 1)
         return center + cyl_type'($urandom_range(0, 32)) - 16'd16;
      r = $urandom_range(0, 5);
      case (r)
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h0001;
         3: return 16'hfffe;
         4: return center;
         default: return center ^ 16'h8000;
      endcase
   endfunction

   task automatic build_stimulus();
      int      k;
      int      style;
      int      r;
      cyl_type center;
      // directed: empty run, single extreme, ties both ways, repeats
      add_cmd(CMD_RUN, 16'd0);
      add_cmd(CMD_LOAD, 16'hffff);
      add_cmd(CMD_RUN, 16'd0);
      add_cmd(CMD_LOAD, 16'd100);
      add_cmd(CMD_LOAD, 16'd300);
      add_cmd(CMD_RUN, 16'd200);
      add_cmd(CMD_LOAD, 16'd300);
      add_cmd(CMD_LOAD, 16'd100);
      add_cmd(CMD_RUN, 16'd200);
      add_cmd(CMD_LOAD, 16'd7);
      add_cmd(CMD_LOAD, 16'd7);
      add_cmd(CMD_LOAD, 16'd7);
      add_cmd(CMD_RUN, 16'd7);
      add_cmd(CMD_LOAD, 16'd0);
      add_cmd(CMD_LOAD, 16'hffff);
      add_cmd(CMD_RUN, 16'h8000);
      add_cmd(CMD_RUN, 16'hffff);
      // first random sequence overfills the store
      k = MAX_REQUESTS + 2;
      while (pending_cmds.size() < ITEM_TARGET) begin
         style = $urandom_range(0, 2);
         center = cyl_type'($urandom_range(0, 65535));
         for (int i = 0; i < k; i++)
            add_cmd(CMD_LOAD, pick_cylinder(style, center));
         add_cmd(CMD_RUN, pick_cylinder($urandom_range(0, 2), center));
         r = $urandom_range(0, 99);
         if (r < 70)
            k = $urandom_range(0, 8);
         else if (r < 92)
            k = $urandom_range(9, MAX_REQUESTS - 1);
         else
            k = $urandom_range(MAX_REQUESTS, MAX_REQUESTS + 4);
      end
   endtask

   always @(posedge clock) begin : drive_proc
      disk_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            schedule_transfer(req_cmd, req_position);
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_cmd <= c.cmd;
               req_position <= c.position;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_proc
      service_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (service_q.size() == 0) begin
               $error("unexpected result transfer, cylinder %0d", rsp_serviced_cylinder);
               failed = 1'b1;
            end else begin
               want = service_q.pop_front();
               if (rsp_serviced_cylinder !== want.cylinder) begin
                  $error("serviced_cylinder: expected %0d, actual %0d",
                         want.cylinder, rsp_serviced_cylinder);
                  failed = 1'b1;
               end
               if (rsp_move_distance !== want.distance) begin
                  $error("move_distance: expected %0d, actual %0d",
                         want.distance, rsp_move_distance);
                  failed = 1'b1;
               end
               if (rsp_total_movement !== want.total) begin
                  $error("total_movement: expected %0d, actual %0d",
                         want.total, rsp_total_movement);
                  failed = 1'b1;
               end
               if (rsp_service_index !== want.index) begin
                  $error("service_index: expected %0d, actual %0d",
                         want.index, rsp_service_index);
                  failed = 1'b1;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  failed = 1'b1;
               end
               if (rsp_empty_res !== want.empty) begin
                  $error("empty_res: expected %0d, actual %0d", want.empty, rsp_empty_res);
                  failed = 1'b1;
               end
            end
         end
         // one long hold-off so loads pile up and a run backs up the input
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (!holdoff_done && results_seen >= 40) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            stall_phase++;
            if (stall_phase >= 64) begin
               stall_phase = 0;
               stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (stall_phase % 4 == 3);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid)
         @(posedge clock);
      while (service_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
